// ===== hw/rtl/mcba_pkg.sv =====
package mcba_pkg;

	localparam int MEM_W = 48;
	localparam int CPU_W = 16;
	localparam int LEASE_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [LEASE_W-1:0] LEASE_MAX = {LEASE_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUDGET_CAP = 1'b0,
		REG_KEEP_BACK  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_NO_BUDGET = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_WAIT      = 3'd3,
		ST_RELEASED  = 3'd4
	} status_t;

	typedef struct packed {
		op_t              operation;
		logic [MEM_W-1:0] memory_amount;
		logic [CPU_W-1:0] cpu_amount;
		logic [MEM_W-1:0] probed_headroom;
		logic [CPU_W-1:0] probed_cpus;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [MEM_W-1:0]   granted_memory;
		logic [CPU_W-1:0]   granted_cpus;
		logic [MEM_W-1:0]   memory_budget_now;
		logic [MEM_W-1:0]   memory_in_use;
		logic [CPU_W-1:0]   cpus_in_use;
		logic [LEASE_W-1:0] active_leases;
	} rsp_t;

	// item after the budget stage
	typedef struct packed {
		op_t              op;
		logic [MEM_W-1:0] budget;
		logic [MEM_W-1:0] mem_amount;
		logic [CPU_W-1:0] cpu_amount;
		logic [CPU_W-1:0] cpu_pick;
		logic [CPU_W-1:0] cpus;
	} stage_t;

endpackage

// ===== hw/rtl/mcba_budget.sv =====
module mcba_budget (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  mcba_pkg::req_t        req,
	input  logic [mcba_pkg::MEM_W-1:0] budget_cap,
	input  logic [mcba_pkg::MEM_W-1:0] keep_back,
	input  logic                  advance,
	output logic                  s1_valid,
	output mcba_pkg::stage_t      s1
);
	import mcba_pkg::*;

	logic [MEM_W-1:0] safe;
	logic [MEM_W-1:0] budget;
	logic [CPU_W-1:0] cpus;
	stage_t           stage_d;

	// headroom less keep-back, floored at zero, then capped
	always_comb begin
		safe   = (req.probed_headroom > keep_back) ? (req.probed_headroom - keep_back) : '0;
		budget = (budget_cap == '0 || safe < budget_cap) ? safe : budget_cap;
	end

	// usable cpus at least one, request clamped to them
	always_comb begin
		cpus = (req.probed_cpus == '0) ? CPU_W'(1) : req.probed_cpus;
		stage_d.op         = req.operation;
		stage_d.budget     = budget;
		stage_d.mem_amount = req.memory_amount;
		stage_d.cpu_amount = req.cpu_amount;
		stage_d.cpus       = cpus;
		stage_d.cpu_pick   = (req.cpu_amount == '0 || req.cpu_amount > cpus) ? cpus
		                                                                      : req.cpu_amount;
	end

	assign req_ready = !s1_valid || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req_ready) begin
			s1_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			s1 <= stage_d;
		end
	end

endmodule

// ===== hw/rtl/mcba_admit.sv =====
module mcba_admit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  mcba_pkg::stage_t s1,
	output logic             advance,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output mcba_pkg::rsp_t   rsp
);
	import mcba_pkg::*;

	logic [MEM_W-1:0]   mem_res_q;
	logic [CPU_W-1:0]   cpu_res_q;
	logic [LEASE_W-1:0] lease_q;

	logic [MEM_W-1:0]   mem_pick;
	logic               mem_fits;
	logic               cpu_room_ok;
	status_t            status;
	logic [MEM_W-1:0]   mem_res_d;
	logic [CPU_W-1:0]   cpu_res_d;
	logic [LEASE_W-1:0] lease_d;
	rsp_t               rsp_d;

	assign advance = !rsp_valid || rsp_ready;

	// fit checks against running totals
	always_comb begin
		mem_pick    = (s1.mem_amount == '0) ? s1.budget : s1.mem_amount;
		mem_fits    = mem_res_q <= (s1.budget - mem_pick);
		cpu_room_ok = cpu_res_q <= (s1.cpus - s1.cpu_pick);
	end

	// decision and next totals
	always_comb begin
		mem_res_d = mem_res_q;
		cpu_res_d = cpu_res_q;
		lease_d   = lease_q;
		rsp_d     = '0;
		if (s1.op == OP_RELEASE) begin
			status    = ST_RELEASED;
			mem_res_d = (s1.mem_amount >= mem_res_q) ? '0 : (mem_res_q - s1.mem_amount);
			cpu_res_d = (s1.cpu_amount >= cpu_res_q) ? '0 : (cpu_res_q - s1.cpu_amount);
			if (lease_q != '0) begin
				lease_d = lease_q - LEASE_W'(1);
			end
		end else if (s1.budget == '0) begin
			status = ST_NO_BUDGET;
		end else if (s1.mem_amount > s1.budget) begin
			status = ST_TOO_LARGE;
		end else if (mem_fits && cpu_room_ok) begin
			status    = ST_GRANTED;
			mem_res_d = mem_res_q + mem_pick;
			cpu_res_d = cpu_res_q + s1.cpu_pick;
			if (lease_q != LEASE_MAX) begin
				lease_d = lease_q + LEASE_W'(1);
			end
			rsp_d.granted_memory = mem_pick;
			rsp_d.granted_cpus   = s1.cpu_pick;
		end else begin
			status = ST_WAIT;
		end
		rsp_d.status            = status;
		rsp_d.memory_budget_now = (s1.op == OP_RELEASE) ? '0 : s1.budget;
		rsp_d.memory_in_use     = mem_res_d;
		rsp_d.cpus_in_use       = cpu_res_d;
		rsp_d.active_leases     = lease_d;
	end

	// totals and result register advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			mem_res_q <= '0;
			cpu_res_q <= '0;
			lease_q   <= '0;
		end else if (advance) begin
			rsp_valid <= s1_valid;
			if (s1_valid) begin
				mem_res_q <= mem_res_d;
				cpu_res_q <= cpu_res_d;
				lease_q   <= lease_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			rsp <= rsp_d;
		end
	end

endmodule

// ===== hw/rtl/memory_cpu_budget_admission.sv =====
// Admission controller for a pooled memory and CPU budget. Each request
// transfer carries an acquire or a release; every item yields exactly one
// response. The block takes one item per clock cycle while the response
// output is not stalled. It has an input register where the memory budget
// (headroom less keep-back, capped) and the CPU clamp are formed, then a
// result register where the fit check runs against the reserved totals,
// which update together with it so that the next item sees them. Write the
// budget cap and keep-back registers only while no item is in flight.
module memory_cpu_budget_admission (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcba_pkg::MEM_W-1:0]    cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  mcba_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output mcba_pkg::rsp_t                rsp
);
	import mcba_pkg::*;

	logic [MEM_W-1:0] budget_cap_q;
	logic [MEM_W-1:0] keep_back_q;
	logic             advance;
	logic             s1_valid;
	stage_t           s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_cap_q <= '0;
			keep_back_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BUDGET_CAP: budget_cap_q <= cfg_data;
				REG_KEEP_BACK:  keep_back_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mcba_budget u_budget (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.budget_cap (budget_cap_q),
		.keep_back  (keep_back_q),
		.advance    (advance),
		.s1_valid   (s1_valid),
		.s1         (s1)
	);

	mcba_admit u_admit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// a grant never exceeds the budget it was checked against
	a_grant_in_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_GRANTED) |->
		(rsp.granted_memory != '0 && rsp.granted_memory <= rsp.memory_budget_now &&
		 rsp.granted_cpus != '0))
		else $error("grant outside budget");

	// refused, waiting and released items carry no grant
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_GRANTED) |->
		(rsp.granted_memory == '0 && rsp.granted_cpus == '0))
		else $error("grant on non-granted status");

	// a full pipe with a stalled result blocks new requests
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request taken while pipe is stalled");

	// a release moves the lease count down by at most one
	a_release_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && s1_valid && s1.op == OP_RELEASE) |=>
		(rsp.active_leases == $past(u_admit.lease_q) ||
		 rsp.active_leases == $past(u_admit.lease_q) - LEASE_W'(1)))
		else $error("release lease count wrong");

endmodule
